// ----- rtl/pidrs_pkg.sv -----
// ----------------------------------------------------------------------------
// pidrs_pkg
// Shared widths, register codes and reset values for the PID controller
// with setpoint ramp and slew limit.
// ----------------------------------------------------------------------------
package pidrs_pkg;

   localparam int unsigned RampPeriodDefault = 10;
   localparam int unsigned DeadbandDefault   = 0;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 24;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_LOOP_MODE      = 3'd0,
      CSR_GAIN_P         = 3'd1,
      CSR_GAIN_I         = 3'd2,
      CSR_GAIN_D         = 3'd3,
      CSR_INTEGRAL_LIMIT = 3'd4,
      CSR_OUTPUT_LIMIT   = 3'd5,
      CSR_SLEW_STEP      = 3'd6,
      CSR_RAMP_STEP      = 3'd7
   } csr_index_type;

   // loop_mode codes
   localparam logic MODE_POSITIONAL  = 1'b0;
   localparam logic MODE_INCREMENTAL = 1'b1;

   localparam logic        LoopModeReset      = MODE_POSITIONAL;
   localparam logic [15:0] GainPReset         = 16'd2560;
   localparam logic [15:0] GainIReset         = 16'd26;
   localparam logic [15:0] GainDReset         = 16'd0;
   localparam logic [23:0] IntegralLimitReset = 24'd65535;
   localparam logic [14:0] OutputLimitReset   = 15'd32767;
   localparam logic [15:0] SlewStepReset      = 16'd65535;
   localparam logic [14:0] RampStepReset      = 15'd100;

   // error_now never reaches this code (range is +-65535)
   localparam logic [16:0] ErrorMostNegative = 17'h10000;

endpackage

// ----- rtl/pid_with_ramp_and_slew_limit.sv -----
// ----------------------------------------------------------------------------
// pid_with_ramp_and_slew_limit
// PID controller with setpoint ramp, deadband, integral clamp, output clamp
// and slew limit; positional or incremental form.
// ----------------------------------------------------------------------------
// Takes one sample word per clock while the result is not stalled and returns
// one result word per sample. Stages: an input register, a loop-state stage
// (ramp, error history, saturating error sum), a multiply stage with the
// three gain products, a stage that sums and shifts them, and the drive
// stage that adds the previous drive in incremental mode, clamps, slew-limits
// and loads the result register. Loop state and previous drive feed back from
// their own registers, so back-to-back samples run at full rate. A stalled
// result holds the whole pipeline. The user must write registers through the
// csr port only while no sample is in flight; the block does not enforce it.
module pid_with_ramp_and_slew_limit #(
   parameter int unsigned RAMP_PERIOD = pidrs_pkg::RampPeriodDefault,
   parameter int unsigned DEADBAND    = pidrs_pkg::DeadbandDefault
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [15:0]                     req_measurement,
   input  logic signed [15:0]                     req_requested_target,
   input  logic                                   req_clear,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [15:0]                     rsp_drive,
   output logic signed [15:0]                     rsp_setpoint_now,
   output logic                                   rsp_ramping,
   output logic signed [16:0]                     rsp_error_now,
   input  logic                                   csr_write_en,
   input  logic [pidrs_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [pidrs_pkg::CsrDataWidth-1:0]     csr_write_data
);

   localparam logic [7:0]        RampLast = 8'(RAMP_PERIOD);
   localparam logic signed [17:0] DbLim  = 18'(DEADBAND);

   // ---------------- configuration registers ----------------
   logic        loop_mode_ff;
   logic [15:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [23:0] integral_limit_ff;
   logic [14:0] output_limit_ff;
   logic [15:0] slew_step_ff;
   logic [14:0] ramp_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         loop_mode_ff      <= pidrs_pkg::LoopModeReset;
         gain_p_ff         <= pidrs_pkg::GainPReset;
         gain_i_ff         <= pidrs_pkg::GainIReset;
         gain_d_ff         <= pidrs_pkg::GainDReset;
         integral_limit_ff <= pidrs_pkg::IntegralLimitReset;
         output_limit_ff   <= pidrs_pkg::OutputLimitReset;
         slew_step_ff      <= pidrs_pkg::SlewStepReset;
         ramp_step_ff      <= pidrs_pkg::RampStepReset;
      end else if (csr_write_en) begin
         case (pidrs_pkg::csr_index_type'(csr_index))
            pidrs_pkg::CSR_LOOP_MODE:      loop_mode_ff      <= csr_write_data[0];
            pidrs_pkg::CSR_GAIN_P:         gain_p_ff         <= csr_write_data[15:0];
            pidrs_pkg::CSR_GAIN_I:         gain_i_ff         <= csr_write_data[15:0];
            pidrs_pkg::CSR_GAIN_D:         gain_d_ff         <= csr_write_data[15:0];
            pidrs_pkg::CSR_INTEGRAL_LIMIT: integral_limit_ff <= csr_write_data[23:0];
            pidrs_pkg::CSR_OUTPUT_LIMIT:   output_limit_ff   <= csr_write_data[14:0];
            pidrs_pkg::CSR_SLEW_STEP:      slew_step_ff      <= csr_write_data[15:0];
            pidrs_pkg::CSR_RAMP_STEP:      ramp_step_ff      <= csr_write_data[14:0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   logic advance;
   logic v0_ff, v1_ff, v2_ff, v3_ff, rsp_valid_ff;

   // whole pipeline moves unless the result word is stalled
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v0_ff        <= req_valid;
         v1_ff        <= v0_ff;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= v3_ff;
      end
   end

   // ---------------- input register ----------------
   logic signed [15:0] meas0_ff, target0_ff;
   logic               clr0_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         meas0_ff   <= req_measurement;
         target0_ff <= req_requested_target;
         clr0_ff    <= req_clear;
      end
   end

   // ---------------- loop state stage ----------------
   logic signed [15:0] setpoint_ff, setpoint_in;
   logic signed [15:0] ramp_goal_ff, ramp_goal_in;
   logic               ramp_active_ff, ramp_active_in;
   logic [7:0]         ramp_counter_ff, ramp_counter_in;
   logic signed [16:0] err_cur_ff, err_cur_in;
   logic signed [16:0] err_prev_ff, err_prev_in;
   logic signed [24:0] err_sum_ff, err_sum_in;

   logic signed [17:0] op_p_in;
   logic signed [24:0] op_i_in;
   logic signed [18:0] op_d_in;

   always_comb begin
      logic signed [15:0] sp, goal;
      logic               act;
      logic [7:0]         cnt;
      logic signed [16:0] ec, ep, sp_step, e;
      logic signed [17:0] e_x, d1;
      logic signed [18:0] d2;
      logic signed [24:0] sm;
      logic signed [25:0] s_raw, s_lim;

      // drop all loop state first on clear
      sp   = clr0_ff ? '0 : setpoint_ff;
      goal = clr0_ff ? '0 : ramp_goal_ff;
      act  = clr0_ff ? 1'b0 : ramp_active_ff;
      cnt  = clr0_ff ? '0 : ramp_counter_ff;
      ec   = clr0_ff ? '0 : err_cur_ff;
      ep   = clr0_ff ? '0 : err_prev_ff;
      sm   = clr0_ff ? '0 : err_sum_ff;
      sp_step = '0;

      if (goal != target0_ff) begin
         goal = target0_ff;
         act  = 1'b1;
      end

      if (act) begin
         if (cnt < RampLast) begin
            cnt = cnt + 8'd1;
         end else begin
            cnt = '0;
            if (sp < goal) begin
               sp_step = {sp[15], sp} + $signed({2'b00, ramp_step_ff});
               if (sp_step >= $signed({goal[15], goal})) begin
                  sp  = goal;
                  act = 1'b0;
               end else begin
                  sp = sp_step[15:0];
               end
            end else if (sp > goal) begin
               sp_step = {sp[15], sp} - $signed({2'b00, ramp_step_ff});
               if (sp_step <= $signed({goal[15], goal})) begin
                  sp  = goal;
                  act = 1'b0;
               end else begin
                  sp = sp_step[15:0];
               end
            end else begin
               act = 1'b0;
            end
         end
      end

      e   = {sp[15], sp} - {meas0_ff[15], meas0_ff};
      e_x = {e[16], e};
      if ((e_x < DbLim) && (e_x > -DbLim)) begin
         e = '0;
      end

      s_raw = {sm[24], sm} + {{9{e[16]}}, e};
      s_lim = $signed({2'b00, integral_limit_ff});
      if (s_raw > s_lim) begin
         s_raw = s_lim;
      end else if (s_raw < -s_lim) begin
         s_raw = -s_lim;
      end

      d1 = {e[16], e} - {ec[16], ec};
      d2 = {e[16], e[16], e} - {ec[16], ec, 1'b0} + {ep[16], ep[16], ep};

      setpoint_in     = sp;
      ramp_goal_in    = goal;
      ramp_active_in  = act;
      ramp_counter_in = cnt;
      err_prev_in     = ec;
      err_cur_in      = e;
      err_sum_in      = s_raw[24:0];

      if (loop_mode_ff == pidrs_pkg::MODE_INCREMENTAL) begin
         op_p_in = d1;
         op_i_in = {{8{e[16]}}, e};
         op_d_in = d2;
      end else begin
         op_p_in = {e[16], e};
         op_i_in = s_raw[24:0];
         op_d_in = {d1[17], d1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff     <= '0;
         ramp_goal_ff    <= '0;
         ramp_active_ff  <= 1'b0;
         ramp_counter_ff <= '0;
         err_cur_ff      <= '0;
         err_prev_ff     <= '0;
         err_sum_ff      <= '0;
      end else if (advance && v0_ff) begin
         setpoint_ff     <= setpoint_in;
         ramp_goal_ff    <= ramp_goal_in;
         ramp_active_ff  <= ramp_active_in;
         ramp_counter_ff <= ramp_counter_in;
         err_cur_ff      <= err_cur_in;
         err_prev_ff     <= err_prev_in;
         err_sum_ff      <= err_sum_in;
      end
   end

   logic signed [17:0] op_p1_ff;
   logic signed [24:0] op_i1_ff;
   logic signed [18:0] op_d1_ff;
   logic signed [15:0] sp1_ff, sp2_ff, sp3_ff;
   logic               ramp1_ff, ramp2_ff, ramp3_ff;
   logic signed [16:0] err1_ff, err2_ff, err3_ff;
   logic               clr1_ff, clr2_ff, clr3_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         op_p1_ff <= op_p_in;
         op_i1_ff <= op_i_in;
         op_d1_ff <= op_d_in;
         sp1_ff   <= setpoint_in;
         ramp1_ff <= ramp_active_in;
         err1_ff  <= err_cur_in;
         clr1_ff  <= clr0_ff;
      end
   end

   // ---------------- multiply stage ----------------
   logic signed [34:0] prod_p_in, prod_p_ff;
   logic signed [41:0] prod_i_in, prod_i_ff;
   logic signed [35:0] prod_d_in, prod_d_ff;

   assign prod_p_in = $signed({1'b0, gain_p_ff}) * op_p1_ff;
   assign prod_i_in = $signed({1'b0, gain_i_ff}) * op_i1_ff;
   assign prod_d_in = $signed({1'b0, gain_d_ff}) * op_d1_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_p_ff <= prod_p_in;
         prod_i_ff <= prod_i_in;
         prod_d_ff <= prod_d_in;
         sp2_ff    <= sp1_ff;
         ramp2_ff  <= ramp1_ff;
         err2_ff   <= err1_ff;
         clr2_ff   <= clr1_ff;
      end
   end

   // ---------------- sum and shift stage ----------------
   logic signed [43:0] acc;
   logic signed [35:0] acc_sh_in, acc_sh_ff;

   assign acc = {{9{prod_p_ff[34]}}, prod_p_ff}
              + {{2{prod_i_ff[41]}}, prod_i_ff}
              + {{8{prod_d_ff[35]}}, prod_d_ff};
   // floor division by 256
   assign acc_sh_in = acc[43:8];

   always_ff @(posedge clock) begin
      if (advance) begin
         acc_sh_ff <= acc_sh_in;
         sp3_ff    <= sp2_ff;
         ramp3_ff  <= ramp2_ff;
         err3_ff   <= err2_ff;
         clr3_ff   <= clr2_ff;
      end
   end

   // ---------------- drive stage ----------------
   logic signed [15:0] drive_prev_ff, drive_prev_in;

   always_comb begin
      logic signed [15:0] dp, dc;
      logic signed [35:0] drv, lim;
      logic signed [16:0] diff, stp, lmt;

      dp  = clr3_ff ? '0 : drive_prev_ff;
      drv = acc_sh_ff;
      if (loop_mode_ff == pidrs_pkg::MODE_INCREMENTAL) begin
         drv = acc_sh_ff + {{20{dp[15]}}, dp};
      end

      lim = $signed({21'b0, output_limit_ff});
      if (drv >= lim) begin
         drv = lim;
      end
      if (drv <= -lim) begin
         drv = -lim;
      end
      dc = drv[15:0];

      stp  = $signed({1'b0, slew_step_ff});
      diff = {dc[15], dc} - {dp[15], dp};
      lmt  = {dp[15], dp};
      if (diff > stp) begin
         lmt = lmt + stp;
         dc  = lmt[15:0];
      end else if (diff < -stp) begin
         lmt = lmt - stp;
         dc  = lmt[15:0];
      end
      drive_prev_in = dc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_prev_ff <= '0;
      end else if (advance && v3_ff) begin
         drive_prev_ff <= drive_prev_in;
      end
   end

   logic signed [15:0] drive_ff, setpoint_out_ff;
   logic               ramping_ff;
   logic signed [16:0] error_out_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         drive_ff        <= drive_prev_in;
         setpoint_out_ff <= sp3_ff;
         ramping_ff      <= ramp3_ff;
         error_out_ff    <= err3_ff;
      end
   end

   assign rsp_drive        = drive_ff;
   assign rsp_setpoint_now = setpoint_out_ff;
   assign rsp_ramping      = ramping_ff;
   assign rsp_error_now    = error_out_ff;

endmodule

// ----- rtl/pidrs_checker.sv -----
// ----------------------------------------------------------------------------
// pidrs_checker
// Port-level checks for the PID controller, bound to the top level.
// ----------------------------------------------------------------------------
module pidrs_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic signed [15:0]  rsp_drive,
   input logic signed [16:0]  rsp_error_now
);

   // no result word right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds the whole pipeline, so the input side stalls too
   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("input accepted while result stalled");

   a_hold_drive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_drive)))
      else $error("stalled result word changed");

   a_error_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_error_now != $signed(pidrs_pkg::ErrorMostNegative)))
      else $error("error out of range");

endmodule

bind pid_with_ramp_and_slew_limit pidrs_checker u_pidrs_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_drive     (rsp_drive),
   .rsp_error_now (rsp_error_now)
);
